[src/gf2_bit_matrix_engine_defines.svh]
// Assertion macros shared by the GF(2) bit-matrix engine RTL.
`ifndef GF2_BIT_MATRIX_ENGINE_DEFINES_SVH
`define GF2_BIT_MATRIX_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
`define GBME_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define GBME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GBME_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GBME_ASSERT(label, clk, rst_n, cond)
`define GBME_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GBME_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/gf2bme_pkg.sv]
// Package with types, constants and helper functions of the GF(2) bit-matrix engine.
`timescale 1ns / 1ps

package gf2bme_pkg;

    localparam int COL_BITS     = 33;
    localparam int CNT_W        = 6;
    localparam int MAX_ROWS_DEF = 32;
    localparam int OP_W         = 4;
    localparam int ROW_IDX_W    = 5;
    localparam int COL_IDX_W    = 6;
    localparam int STATUS_W     = 2;
    localparam int CFG_W        = 6;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    localparam logic [CFG_W-1:0]    ROWS_RESET      = 6'd32;
    localparam logic [ADDR_W-3:0]   REG_ROWS_IN_USE = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_READ       = 4'd0,
        OP_ADD_COL    = 4'd1,
        OP_ADD_ROW    = 4'd2,
        OP_ROW_WEIGHT = 4'd3,
        OP_COL_WEIGHT = 4'd4,
        OP_SWAP       = 4'd5,
        OP_APPEND     = 4'd6,
        OP_ROW_MASK   = 4'd7,
        OP_PAIR_MASK  = 4'd8,
        OP_DROP       = 4'd9
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_LIMIT = 2'd2
    } status_t;

    // Ones in every column position below the given column count.
    function automatic logic [COL_BITS-1:0] used_mask(input logic [CNT_W-1:0] cnt);
        logic [COL_BITS-1:0] m;
        for (int i = 0; i < COL_BITS; i++) begin
            m[i] = (CNT_W'(i) < cnt);
        end
        return m;
    endfunction

    function automatic logic [CNT_W-1:0] popcount(input logic [COL_BITS-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < COL_BITS; i++) begin
            c = c + CNT_W'(v[i]);
        end
        return c;
    endfunction

endpackage

[src/gf2_bit_matrix_engine.sv]
// GF(2) bit-matrix engine: input register, one pass of row and column logic, result register.
// Throughput: one item per cycle while a waiting result is taken; the matrix and column count update in that same pass.
// The result register lets a new item enter while a finished result still waits.
// Reset clears the whole matrix and the column count and sets rows_in_use to 32.
`timescale 1ns / 1ps
`include "gf2_bit_matrix_engine_defines.svh"

module gf2_bit_matrix_engine #(
    parameter int MAX_ROWS = gf2bme_pkg::MAX_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gf2bme_pkg::ADDR_W-1:0]       paddr,
    input  logic [gf2bme_pkg::DATA_W-1:0]       pwdata,
    output logic [gf2bme_pkg::DATA_W-1:0]       prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic [gf2bme_pkg::OP_W-1:0]         op,
    input  logic [gf2bme_pkg::ROW_IDX_W-1:0]    first_row,
    input  logic [gf2bme_pkg::ROW_IDX_W-1:0]    second_row,
    input  logic [gf2bme_pkg::COL_IDX_W-1:0]    first_col,
    input  logic [gf2bme_pkg::COL_IDX_W-1:0]    second_col,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [gf2bme_pkg::STATUS_W-1:0]     status,
    output logic                                bit_value,
    output logic [gf2bme_pkg::CNT_W-1:0]        weight,
    output logic [gf2bme_pkg::COL_BITS-1:0]     column_mask,
    output logic [gf2bme_pkg::CNT_W-1:0]        columns_used
);
    import gf2bme_pkg::*;

    localparam int NW = $clog2(MAX_ROWS + 1);
    localparam int RW = (NW > CFG_W) ? NW : CFG_W;

    logic [CFG_W-1:0]       rows_in_use_reg;
    logic [COL_BITS-1:0]    rows_reg [MAX_ROWS];
    logic [COL_BITS-1:0]    rows_next [MAX_ROWS];
    logic [CNT_W-1:0]       cc_reg;
    logic [CNT_W-1:0]       cc_next;

    logic                   s1_valid_reg;
    logic [OP_W-1:0]        s1_op_reg;
    logic [ROW_IDX_W-1:0]   s1_j_reg;
    logic [ROW_IDX_W-1:0]   s1_k_reg;
    logic [COL_IDX_W-1:0]   s1_h_reg;
    logic [COL_IDX_W-1:0]   s1_kc_reg;

    logic                   result_valid_reg;
    status_t                status_reg;
    status_t                status_next;
    logic                   bit_reg;
    logic                   bit_next;
    logic [CNT_W-1:0]       weight_reg;
    logic [CNT_W-1:0]       weight_next;
    logic [COL_BITS-1:0]    mask_reg;
    logic [COL_BITS-1:0]    mask_next;

    logic                   advance;
    logic                   cfg_write;
    logic [RW-1:0]          rows_cfg;
    logic [RW-1:0]          n_rows;
    logic [RW:0]            col_limit;
    logic [MAX_ROWS-1:0]    lane_active;
    logic [MAX_ROWS-1:0]    sel_j;
    logic [COL_BITS-1:0]    row_j;
    logic [COL_BITS-1:0]    row_k;
    logic [COL_BITS-1:0]    used;
    logic [COL_BITS-1:0]    h_oh;
    logic [COL_BITS-1:0]    kc_oh;
    logic [COL_BITS-1:0]    last_oh;
    logic [COL_BITS-1:0]    nb_oh;
    logic [CNT_W-1:0]       column_sum;
    logic                   j_ok;
    logic                   k_ok;
    logic                   h_ok;
    logic                   kc_ok;
    logic                   append_full;
    logic                   result_err;
    logic                   result_fields_zero;
    logic                   mask_outside;

    assign advance    = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_ROWS_IN_USE);
    assign prdata    = (paddr[ADDR_W-1:2] == REG_ROWS_IN_USE) ? DATA_W'(rows_in_use_reg) : '0;

    always_comb
    begin
        rows_cfg = RW'(rows_in_use_reg);
        if (rows_cfg == '0)
        begin
            n_rows = RW'(1);
        end
        else if (rows_cfg > RW'(MAX_ROWS))
        begin
            n_rows = RW'(MAX_ROWS);
        end
        else
        begin
            n_rows = rows_cfg;
        end
        if ((RW + 1)'(n_rows) + 1'b1 > (RW + 1)'(COL_BITS))
        begin
            col_limit = (RW + 1)'(COL_BITS);
        end
        else
        begin
            col_limit = (RW + 1)'(n_rows) + 1'b1;
        end
    end

    assign j_ok        = RW'(s1_j_reg) < n_rows;
    assign k_ok        = RW'(s1_k_reg) < n_rows;
    assign h_ok        = s1_h_reg < cc_reg;
    assign kc_ok       = s1_kc_reg < cc_reg;
    assign append_full = (RW + 1)'(cc_reg) >= col_limit;
    assign used        = used_mask(cc_reg);
    assign h_oh        = h_ok ? (COL_BITS'(1) << s1_h_reg) : '0;
    assign kc_oh       = kc_ok ? (COL_BITS'(1) << s1_kc_reg) : '0;
    assign last_oh     = (cc_reg != '0) ? (COL_BITS'(1) << (cc_reg - 1'b1)) : '0;
    assign nb_oh       = COL_BITS'(1) << cc_reg;

    always_comb
    begin
        row_j      = '0;
        row_k      = '0;
        column_sum = '0;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            lane_active[r] = RW'(r) < n_rows;
            sel_j[r]       = RW'(r) == RW'(s1_j_reg);
            if (sel_j[r])
            begin
                row_j = rows_reg[r];
            end
            if (RW'(r) == RW'(s1_k_reg))
            begin
                row_k = rows_reg[r];
            end
            if (lane_active[r])
            begin
                column_sum = column_sum + CNT_W'(|(rows_reg[r] & h_oh));
            end
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        bit_next    = 1'b0;
        weight_next = '0;
        mask_next   = '0;
        cc_next     = cc_reg;
        rows_next   = rows_reg;
        unique case (op_t'(s1_op_reg))
            OP_READ:
            begin
                if (j_ok && h_ok)
                begin
                    bit_next = |(row_j & h_oh);
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            OP_ADD_COL:
            begin
                if (h_ok && kc_ok)
                begin
                    for (int r = 0; r < MAX_ROWS; r++)
                    begin
                        if (lane_active[r] && |(rows_reg[r] & kc_oh))
                        begin
                            rows_next[r] = rows_reg[r] ^ h_oh;
                        end
                    end
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            OP_ADD_ROW:
            begin
                if (j_ok && k_ok)
                begin
                    for (int r = 0; r < MAX_ROWS; r++)
                    begin
                        if (sel_j[r])
                        begin
                            rows_next[r] = rows_reg[r] ^ (row_k & used);
                        end
                    end
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            OP_ROW_WEIGHT:
            begin
                if (j_ok)
                begin
                    weight_next = popcount(row_j & used);
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            OP_COL_WEIGHT:
            begin
                if (h_ok)
                begin
                    weight_next = column_sum;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            OP_SWAP:
            begin
                if (cc_reg == '0)
                begin
                    status_next = ST_LIMIT;
                end
                else if (!h_ok)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    for (int r = 0; r < MAX_ROWS; r++)
                    begin
                        if (lane_active[r]
                            && ((|(rows_reg[r] & h_oh)) != (|(rows_reg[r] & last_oh))))
                        begin
                            rows_next[r] = rows_reg[r] ^ (h_oh | last_oh);
                        end
                    end
                end
            end
            OP_APPEND:
            begin
                if (!j_ok)
                begin
                    status_next = ST_RANGE;
                end
                else if (append_full)
                begin
                    status_next = ST_LIMIT;
                end
                else
                begin
                    for (int r = 0; r < MAX_ROWS; r++)
                    begin
                        if (sel_j[r])
                        begin
                            rows_next[r] = (rows_reg[r] & ~used & ~nb_oh) | nb_oh;
                        end
                        else if (lane_active[r])
                        begin
                            rows_next[r] = rows_reg[r] & ~nb_oh;
                        end
                    end
                    cc_next = cc_reg + 1'b1;
                end
            end
            OP_ROW_MASK:
            begin
                if (j_ok)
                begin
                    mask_next = row_j & used;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            OP_PAIR_MASK:
            begin
                if (j_ok && k_ok)
                begin
                    mask_next = row_j & row_k & used;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            OP_DROP:
            begin
                if (cc_reg == '0)
                begin
                    status_next = ST_LIMIT;
                end
                else
                begin
                    cc_next = cc_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg  <= ROWS_RESET;
            cc_reg           <= '0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int r = 0; r < MAX_ROWS; r++)
            begin
                rows_reg[r] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                rows_in_use_reg <= pwdata[CFG_W-1:0];
            end
            if (item_valid && item_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                cc_reg           <= cc_next;
                rows_reg         <= rows_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_op_reg <= op;
            s1_j_reg  <= first_row;
            s1_k_reg  <= second_row;
            s1_h_reg  <= first_col;
            s1_kc_reg <= second_col;
        end
        if (advance)
        begin
            status_reg <= status_next;
            bit_reg    <= bit_next;
            weight_reg <= weight_next;
            mask_reg   <= mask_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign bit_value    = bit_reg;
    assign weight       = weight_reg;
    assign column_mask  = mask_reg;
    assign columns_used = cc_reg;

    assign result_err         = result_valid_reg && (status_reg != ST_OK);
    assign result_fields_zero = !bit_reg && (weight_reg == '0) && (mask_reg == '0);
    assign mask_outside       = |(mask_reg & ~used);

    `GBME_ASSERT(a_cc_bound, clk, rst_n, cc_reg <= CNT_W'(COL_BITS))
    `GBME_ASSERT_NXT(a_cc_hold, clk, rst_n, !advance, $stable(cc_reg))
    `GBME_ASSERT_NXT(a_cc_step, clk, rst_n, 1'b1, CNT_W'(cc_reg - $past(cc_reg) + 1'b1) <= 2'd2)
    `GBME_ASSERT_IMP(a_err_zero, clk, rst_n, result_err, result_fields_zero)
    `GBME_ASSERT_IMP(a_mask_used, clk, rst_n, result_valid_reg, !mask_outside)

endmodule

[verif/testbench.sv]
// Self-checking testbench for the GF(2) bit-matrix engine with a scoreboard that predicts results.
`timescale 1ns / 1ps

module testbench;
    import gf2bme_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [ROW_IDX_W-1:0] first_row;
        logic [ROW_IDX_W-1:0] second_row;
        logic [COL_IDX_W-1:0] first_col;
        logic [COL_IDX_W-1:0] second_col;
    } matrix_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                bit_value;
        logic [CNT_W-1:0]    weight;
        logic [COL_BITS-1:0] column_mask;
        logic [CNT_W-1:0]    columns_used;
    } matrix_result_t;

    class matrix_scoreboard;
        logic [COL_BITS-1:0] grid [MAX_ROWS_DEF];
        int unsigned         col_count;
        int unsigned         rows_setting;
        matrix_result_t      awaited_results [$];
        int unsigned         failures;

        function new();
            foreach (grid[r]) grid[r] = '0;
            col_count    = 0;
            rows_setting = ROWS_RESET;
            failures     = 0;
        endfunction

        function int unsigned active_rows();
            if (rows_setting < 1) return 1;
            if (rows_setting > MAX_ROWS_DEF) return MAX_ROWS_DEF;
            return rows_setting;
        endfunction

        function void apply_command(matrix_cmd_t c);
            matrix_result_t      res;
            logic [COL_BITS-1:0] used;
            logic                a;
            int unsigned         n;
            int unsigned         limit;
            int unsigned         last;
            bit                  j_ok;
            bit                  k_ok;
            bit                  h_ok;
            res = '0;
            n = active_rows();
            for (int i = 0; i < COL_BITS; i++) used[i] = (i < col_count);
            j_ok = c.first_row < n;
            k_ok = c.second_row < n;
            h_ok = c.first_col < col_count;
            unique case (c.op)
                OP_READ:
                    if (j_ok && h_ok) res.bit_value = grid[c.first_row][c.first_col];
                    else res.status = ST_RANGE;
                OP_ADD_COL:
                    if (h_ok && c.second_col < col_count)
                    begin
                        for (int r = 0; r < n; r++)
                            grid[r][c.first_col] = grid[r][c.first_col]
                                                   ^ grid[r][c.second_col];
                    end
                    else res.status = ST_RANGE;
                OP_ADD_ROW:
                    if (j_ok && k_ok)
                        grid[c.first_row] = grid[c.first_row] ^ (grid[c.second_row] & used);
                    else res.status = ST_RANGE;
                OP_ROW_WEIGHT:
                    if (j_ok)
                    begin
                        for (int i = 0; i < COL_BITS; i++)
                            res.weight = res.weight + CNT_W'(grid[c.first_row][i] & used[i]);
                    end
                    else res.status = ST_RANGE;
                OP_COL_WEIGHT:
                    if (h_ok)
                    begin
                        for (int r = 0; r < n; r++)
                            res.weight = res.weight + CNT_W'(grid[r][c.first_col]);
                    end
                    else res.status = ST_RANGE;
                OP_SWAP:
                    if (col_count == 0) res.status = ST_LIMIT;
                    else if (!h_ok) res.status = ST_RANGE;
                    else
                    begin
                        last = col_count - 1;
                        for (int r = 0; r < n; r++)
                        begin
                            a = grid[r][c.first_col];
                            grid[r][c.first_col] = grid[r][last];
                            grid[r][last] = a;
                        end
                    end
                OP_APPEND:
                begin
                    limit = (n + 1 > COL_BITS) ? COL_BITS : n + 1;
                    if (!j_ok) res.status = ST_RANGE;
                    else if (col_count >= limit) res.status = ST_LIMIT;
                    else
                    begin
                        grid[c.first_row] = grid[c.first_row] & ~used;
                        for (int r = 0; r < n; r++) grid[r][col_count] = 1'b0;
                        grid[c.first_row][col_count] = 1'b1;
                        col_count++;
                    end
                end
                OP_ROW_MASK:
                    if (j_ok) res.column_mask = grid[c.first_row] & used;
                    else res.status = ST_RANGE;
                OP_PAIR_MASK:
                    if (j_ok && k_ok)
                        res.column_mask = grid[c.first_row] & grid[c.second_row] & used;
                    else res.status = ST_RANGE;
                OP_DROP:
                    if (col_count == 0) res.status = ST_LIMIT;
                    else col_count--;
                default:
                    res.status = ST_RANGE;
            endcase
            res.columns_used = CNT_W'(col_count);
            awaited_results.insert(awaited_results.size(), res);
        endfunction

        function void check_result(matrix_result_t got);
            matrix_result_t want;
            if (awaited_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("Result transfer with no result awaited: status=%0d columns_used=%0d",
                             got.status, got.columns_used);
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status || got.bit_value !== want.bit_value
                || got.weight !== want.weight || got.column_mask !== want.column_mask
                || got.columns_used !== want.columns_used)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("Mismatch, expected: status=%0d bit=%0b weight=%0d mask=%h cols=%0d",
                             want.status, want.bit_value, want.weight, want.column_mask,
                             want.columns_used);
                    $display("            actual: status=%0d bit=%0b weight=%0d mask=%h cols=%0d",
                             got.status, got.bit_value, got.weight, got.column_mask,
                             got.columns_used);
                end
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT      = 400000;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int RANDOM_PER_PHASE = 145;
    localparam int NUM_PHASES       = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 item_valid;
    logic                 item_ready;
    logic [OP_W-1:0]      op;
    logic [ROW_IDX_W-1:0] first_row;
    logic [ROW_IDX_W-1:0] second_row;
    logic [COL_IDX_W-1:0] first_col;
    logic [COL_IDX_W-1:0] second_col;
    logic                 result_valid;
    logic                 result_ready;
    logic [STATUS_W-1:0]  status;
    logic                 bit_value;
    logic [CNT_W-1:0]     weight;
    logic [COL_BITS-1:0]  column_mask;
    logic [CNT_W-1:0]     columns_used;

    matrix_scoreboard board;
    int unsigned      cycle_count = 0;

    gf2_bit_matrix_engine uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic write_rows_in_use(input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ROWS_IN_USE, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.rows_setting = value;
    endtask

    task automatic send_command(input matrix_cmd_t c, input bit burst);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        op         <= c.op;
        first_row  <= c.first_row;
        second_row <= c.second_row;
        first_col  <= c.first_col;
        second_col <= c.second_col;
        do @(posedge clk); while (!item_ready);
        board.apply_command(c);
    endtask

    task automatic wait_until_drained();
        item_valid <= 1'b0;
        while (board.awaited_results.size() != 0) @(posedge clk);
    endtask

    function automatic matrix_cmd_t make_cmd(input logic [OP_W-1:0] o, input int unsigned j,
                                             input int unsigned k, input int unsigned h,
                                             input int unsigned kc);
        matrix_cmd_t c;
        c.op         = o;
        c.first_row  = ROW_IDX_W'(j);
        c.second_row = ROW_IDX_W'(k);
        c.first_col  = COL_IDX_W'(h);
        c.second_col = COL_IDX_W'(kc);
        return c;
    endfunction

    // Mix 0 favors appends, mix 1 is balanced, mix 2 favors drops.
    function automatic matrix_cmd_t random_command(input int unsigned mix);
        matrix_cmd_t c;
        op_t         others [8] = '{OP_READ, OP_ADD_COL, OP_ADD_ROW, OP_ROW_WEIGHT,
                                    OP_COL_WEIGHT, OP_SWAP, OP_ROW_MASK, OP_PAIR_MASK};
        int unsigned n;
        int unsigned cols;
        int unsigned pick;
        int unsigned app;
        int unsigned drp;
        n    = board.active_rows();
        cols = board.col_count;
        app  = (mix == 0) ? 35 : (mix == 1) ? 15 : 8;
        drp  = (mix == 0) ? 8 : (mix == 1) ? 12 : 30;
        pick = $urandom_range(0, 99);
        if (pick < app) c.op = OP_APPEND;
        else if (pick < app + drp) c.op = OP_DROP;
        else if (pick < app + drp + 1) c.op = OP_W'($urandom_range(10, 15));
        else c.op = others[$urandom_range(0, 7)];
        if ($urandom_range(0, 99) < 88)
        begin
            c.first_row  = ROW_IDX_W'($urandom_range(0, n - 1));
            c.second_row = ROW_IDX_W'($urandom_range(0, n - 1));
            c.first_col  = (cols != 0) ? COL_IDX_W'($urandom_range(0, cols - 1)) : '0;
            c.second_col = (cols != 0) ? COL_IDX_W'($urandom_range(0, cols - 1)) : '0;
        end
        else
        begin
            c.first_row  = ROW_IDX_W'($urandom_range(0, 31));
            c.second_row = ROW_IDX_W'($urandom_range(0, 31));
            c.first_col  = COL_IDX_W'($urandom_range(0, COL_BITS - 1));
            c.second_col = COL_IDX_W'($urandom_range(0, COL_BITS - 1));
        end
        return c;
    endfunction

    initial
    begin
        int unsigned taken;
        int unsigned stall;
        matrix_result_t got;
        result_ready <= 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken == 150 || taken == 700) stall = HOLD_OFF_CYCLES;
            else if ((taken / 30) % 4 == 1) stall = 0;
            else stall = $urandom_range(0, 12);
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            got.status       = status;
            got.bit_value    = bit_value;
            got.weight       = weight;
            got.column_mask  = column_mask;
            got.columns_used = columns_used;
            board.check_result(got);
            taken++;
        end
    end

    initial
    begin
        int unsigned row_plan [NUM_PHASES];
        int unsigned mix_plan [NUM_PHASES];
        int unsigned rows;
        row_plan   = '{32, 1, 2, 32, 0, 17, 32, 0, 31, 32};
        mix_plan   = '{0, 1, 2, 0, 1, 2, 0, 1, 2, 1};
        board      = new();
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        item_valid <= 1'b0;
        op         <= '0;
        first_row  <= '0;
        second_row <= '0;
        first_col  <= '0;
        second_col <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_rows_in_use(32);

        // Empty matrix limits, unknown operations, then a small matrix built by appends.
        send_command(make_cmd(OP_SWAP, 0, 0, 0, 0), 1'b0);
        send_command(make_cmd(OP_DROP, 0, 0, 0, 0), 1'b0);
        send_command(make_cmd(OP_READ, 0, 0, 0, 0), 1'b0);
        send_command(make_cmd(4'd13, 31, 31, 32, 32), 1'b0);
        send_command(make_cmd(4'd15, 0, 0, 0, 0), 1'b0);
        send_command(make_cmd(OP_APPEND, 31, 0, 0, 0), 1'b0);
        send_command(make_cmd(OP_APPEND, 0, 0, 0, 0), 1'b1);
        send_command(make_cmd(OP_APPEND, 5, 0, 0, 0), 1'b1);
        send_command(make_cmd(OP_ADD_COL, 0, 0, 0, 2), 1'b0);
        send_command(make_cmd(OP_ADD_COL, 0, 0, 1, 1), 1'b0);
        send_command(make_cmd(OP_ADD_COL, 0, 0, 3, 0), 1'b0);
        send_command(make_cmd(OP_ADD_ROW, 31, 0, 0, 0), 1'b0);
        send_command(make_cmd(OP_ADD_ROW, 5, 5, 0, 0), 1'b0);
        send_command(make_cmd(OP_ROW_WEIGHT, 31, 0, 0, 0), 1'b0);
        send_command(make_cmd(OP_COL_WEIGHT, 0, 0, 2, 0), 1'b0);
        send_command(make_cmd(OP_COL_WEIGHT, 0, 0, 32, 0), 1'b0);
        send_command(make_cmd(OP_SWAP, 0, 0, 0, 0), 1'b0);
        send_command(make_cmd(OP_ROW_MASK, 31, 0, 0, 0), 1'b0);
        send_command(make_cmd(OP_PAIR_MASK, 0, 31, 0, 0), 1'b0);
        send_command(make_cmd(OP_READ, 31, 0, 2, 0), 1'b0);
        send_command(make_cmd(OP_DROP, 0, 0, 0, 0), 1'b0);
        wait_until_drained();

        // With one active row the column limit is two, and the row index is checked first.
        write_rows_in_use(1);
        send_command(make_cmd(OP_READ, 1, 0, 0, 0), 1'b0);
        send_command(make_cmd(OP_APPEND, 0, 0, 0, 0), 1'b0);
        send_command(make_cmd(OP_APPEND, 3, 0, 0, 0), 1'b0);
        send_command(make_cmd(OP_ROW_WEIGHT, 31, 0, 0, 0), 1'b0);
        wait_until_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            rows = (row_plan[p] == 0) ? $urandom_range(3, 30) : row_plan[p];
            write_rows_in_use(rows);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                send_command(random_command(mix_plan[p]), ((i / 40) % 4) == 3);
            wait_until_drained();
        end

        repeat (8) @(posedge clk);
        if (board.failures == 0 && board.awaited_results.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

[filelist.f]
+incdir+src
src/gf2bme_pkg.sv
src/gf2_bit_matrix_engine.sv
verif/testbench.sv
